// File: src/semi_pkg.sv
`timescale 1ns / 1ps
package semi_pkg;
    localparam logic CMD_EVAL  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [1:0] SEL_ETH  = 2'd0;
    localparam logic [1:0] SEL_TEMP = 2'd1;
    localparam logic [1:0] SEL_MAP  = 2'd2;
    localparam logic [1:0] SEL_ADV  = 2'd3;

    localparam logic [2:0] MODE_INIT     = 3'd0;
    localparam logic [2:0] MODE_OFF      = 3'd1;
    localparam logic [2:0] MODE_OK       = 3'd2;
    localparam logic [2:0] MODE_HOLD     = 3'd3;
    localparam logic [2:0] MODE_OVERRIDE = 3'd5;

    localparam logic [2:0] REG_FUEL_EN   = 3'd0;
    localparam logic [2:0] REG_ADV_EN    = 3'd1;
    localparam logic [2:0] REG_FUEL_CEIL = 3'd2;
    localparam logic [2:0] REG_ADV_TMAX  = 3'd3;
    localparam logic [2:0] REG_ADV_CEIL  = 3'd4;

    // divider request/response
    typedef struct packed {
        logic        start;
        logic [15:0] num;   // key - lo, below den whenever start is set
        logic [15:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [15:0] quo;
    } t_div_rsp;
endpackage

// File: src/semi_div.sv
`timescale 1ns / 1ps
module semi_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  semi_pkg::t_div_req i_req,
    output semi_pkg::t_div_rsp o_rsp
);
    import semi_pkg::*;

    // restoring division of (num << 16) by den, one quotient bit a cycle
    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [16:0] r_rem;
    logic [15:0] r_quo;
    logic [15:0] r_den;
    logic        r_done;
    logic [16:0] w_trial;
    logic [17:0] w_diff;

    assign w_trial = {r_rem[15:0], 1'b0};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd16;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {1'b0, i_req.num};
            r_den <= i_req.den;
            r_quo <= '0;
        end else if (r_busy) begin
            if (!w_diff[17]) begin
                r_rem <= w_diff[16:0];
                r_quo <= {r_quo[14:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_quo <= {r_quo[14:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule

// File: src/start_enrichment_map_interp.sv
`timescale 1ns / 1ps
// Start enrichment map interpolation engine.
// An evaluate raises o_valid after the segment walks, up to two passes of the shared
// bit-serial divider and four passes of the shared lerp; a table write is registered
// on acceptance.
// Throughput: one transaction at a time; stall is raised while an item is in work.
// Reset (synchronous, active low) restores tables, config and state; map cells read unity.
module start_enrichment_map_interp #(
    parameter int AXIS_POINTS      = 6,
    parameter int FUEL_HARD_MAX    = 2560,
    parameter int FUEL_UNITY       = 1024,
    parameter int ADVANCE_HARD_MAX = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [1:0]  i_table_select,
    input  logic [5:0]  i_table_index,
    input  logic [15:0] i_table_value,
    input  logic [2:0]  i_engine_mode,
    input  logic [15:0] i_ethanol_estimate,
    input  logic [7:0]  i_coolant_count,
    input  logic        i_cal_valid,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_start_factor,
    output logic [6:0]  o_start_advance
);
    import semi_pkg::*;

    localparam int NP    = AXIS_POINTS;
    localparam int CELLS = NP * NP;
    localparam int IW    = $clog2(NP);
    localparam int CW    = $clog2(CELLS + NP + 2);
    localparam int MW    = $clog2(CELLS);

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SRCH  = 4'd1;
    localparam logic [3:0] ST_DIV   = 4'd2;
    localparam logic [3:0] ST_LD    = 4'd3;
    localparam logic [3:0] ST_LERP  = 4'd4;
    localparam logic [3:0] ST_ADD   = 4'd5;
    localparam logic [3:0] ST_FIN   = 4'd6;
    localparam logic [3:0] ST_OUT   = 4'd7;
    localparam logic [3:0] ST_RD    = 4'd8;

    // axis and curve tables are registers; the map is a memory with a written mark per cell
    logic [7:0]  r_eth_ax  [NP];
    logic [7:0]  r_tmp_ax  [NP];
    logic [7:0]  r_adv_cv  [NP];
    logic [15:0] r_map     [CELLS];
    logic [CELLS-1:0] r_map_set;
    logic [15:0] r_m0, r_m1;

    logic        r_fuel_en, r_adv_en;
    logic [15:0] r_fuel_ceil;
    logic [7:0]  r_adv_tmax, r_adv_ceil;

    logic [3:0]  r_st;
    logic        r_axis;      // 0 ethanol, 1 temperature
    logic [IW-1:0] r_i;
    logic [IW-1:0] r_ie, r_it;
    logic [15:0] r_fe, r_ft;
    logic        r_fuel_on, r_adv_on;
    logic [15:0] r_eth;
    logic [7:0]  r_tc;
    logic [2:0]  r_step;      // lerp step: 0 top, 1 bottom, 2 vertical, 3 advance
    logic signed [17:0] r_a, r_b, r_v, r_w;
    logic signed [34:0] r_prod;
    logic        r_oval;
    logic [11:0] r_of;
    logic [6:0]  r_oa;

    t_div_req w_req;
    t_div_rsp w_rsp;

    semi_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    // a waiting result does not block the input; the sequencer holds before the clamp
    logic w_in_acc;
    assign w_in_acc = i_valid && !o_stall;
    assign o_stall  = (r_st != ST_IDLE);

    // search key and current segment, scaled to a common 16-bit space
    logic [15:0] w_key, w_lo, w_hi, w_first, w_last;
    logic [7:0]  w_lo8, w_hi8, w_f8, w_l8;
    always_comb begin
        w_lo8 = r_axis ? r_tmp_ax[r_i] : r_eth_ax[r_i];
        w_hi8 = (32'(r_i) + 1 < NP) ? (r_axis ? r_tmp_ax[r_i + 1'b1] : r_eth_ax[r_i + 1'b1])
                                     : 8'd0;
        w_f8  = r_axis ? r_tmp_ax[0] : r_eth_ax[0];
        w_l8  = r_axis ? r_tmp_ax[NP-1] : r_eth_ax[NP-1];
        w_key = r_axis ? {8'd0, r_tc} : r_eth;
        w_lo  = r_axis ? {8'd0, w_lo8} : {4'd0, w_lo8, 4'd0};
        w_hi  = r_axis ? {8'd0, w_hi8} : {4'd0, w_hi8, 4'd0};
        w_first = r_axis ? {8'd0, w_f8} : {4'd0, w_f8, 4'd0};
        w_last  = r_axis ? {8'd0, w_l8} : {4'd0, w_l8, 4'd0};
    end

    // clamped map corner and sign-extended curve point
    function automatic logic signed [17:0] corner(input logic [15:0] v);
        corner = (v > 16'(FUEL_HARD_MAX)) ? 18'(FUEL_HARD_MAX) : {2'b00, v};
    endfunction

    logic [CW-1:0] w_p, w_ra0, w_ra1;
    assign w_p   = CW'(r_it) + CW'(NP) * CW'(r_ie);
    assign w_ra0 = (r_step == 3'd0) ? w_p : w_p + CW'(NP);
    assign w_ra1 = w_ra0 + CW'(1);

    logic signed [17:0] w_cv0, w_cv1;
    assign w_cv0 = {{10{r_adv_cv[r_ie][7]}}, r_adv_cv[r_ie]};
    assign w_cv1 = (32'(r_ie) + 1 < NP) ? {{10{r_adv_cv[r_ie+1'b1][7]}}, r_adv_cv[r_ie+1'b1]}
                                       : 18'sd0;

    logic [15:0] w_frac;
    assign w_frac = (r_step == 3'd2 || r_step == 3'd3) ? r_fe : r_ft;

    // floor(prod / 65536): the arithmetic shift gives floor
    logic signed [17:0] w_lerp;
    assign w_lerp = r_a + 18'(r_prod >>> 16);

    logic [11:0] w_fceil;
    always_comb begin
        if (r_fuel_ceil > 16'(FUEL_HARD_MAX))   w_fceil = 12'(FUEL_HARD_MAX);
        else if (r_fuel_ceil < 16'(FUEL_UNITY)) w_fceil = 12'(FUEL_UNITY);
        else                                    w_fceil = r_fuel_ceil[11:0];
    end
    logic [7:0] w_aceil;
    assign w_aceil = (r_adv_ceil > 8'(ADVANCE_HARD_MAX)) ? 8'(ADVANCE_HARD_MAX) : r_adv_ceil;

    always_comb begin
        w_req.start = 1'b0;
        w_req.num   = w_key - w_lo;
        w_req.den   = w_hi - w_lo;
        if (r_st == ST_SRCH && !(w_key <= w_first) && !(w_key >= w_last)
            && w_key >= w_lo && w_key < w_hi && w_hi > w_lo)
            w_req.start = 1'b1;
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fuel_en   <= 1'b0;
            r_adv_en    <= 1'b0;
            r_fuel_ceil <= 16'd1024;
            r_adv_tmax  <= '0;
            r_adv_ceil  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FUEL_EN:   r_fuel_en   <= i_cfg_data[0];
                REG_ADV_EN:    r_adv_en    <= i_cfg_data[0];
                REG_FUEL_CEIL: r_fuel_ceil <= i_cfg_data;
                REG_ADV_TMAX:  r_adv_tmax  <= i_cfg_data[7:0];
                REG_ADV_CEIL:  r_adv_ceil  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic w_map_we;
    assign w_map_we = i_rst_n && w_in_acc && i_command == CMD_WRITE
                      && i_table_select == SEL_MAP && 32'(i_table_index) < CELLS;

    // table writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NP; k++) begin
                r_eth_ax[k] <= '0;
                r_tmp_ax[k] <= '0;
                r_adv_cv[k] <= '0;
            end
            r_map_set <= '0;
        end else if (w_in_acc && i_command == CMD_WRITE) begin
            if (i_table_select == SEL_MAP) begin
                if (32'(i_table_index) < CELLS)
                    r_map_set[i_table_index[MW-1:0]] <= 1'b1;
            end else if (32'(i_table_index) < NP) begin
                case (i_table_select)
                    SEL_ETH:  r_eth_ax[i_table_index[IW-1:0]] <= i_table_value[7:0];
                    SEL_TEMP: r_tmp_ax[i_table_index[IW-1:0]] <= i_table_value[7:0];
                    default:  r_adv_cv[i_table_index[IW-1:0]] <= i_table_value[7:0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_map_we) r_map[i_table_index[MW-1:0]] <= i_table_value;
    end

    // registered read of the two corners of one map row; unwritten cells read unity
    always_ff @(posedge i_clk) begin
        if (r_st == ST_RD) begin
            if (32'(w_ra0) >= CELLS)       r_m0 <= '0;
            else if (r_map_set[w_ra0[MW-1:0]]) r_m0 <= r_map[w_ra0[MW-1:0]];
            else                           r_m0 <= 16'(FUEL_UNITY);
            if (32'(w_ra1) >= CELLS)       r_m1 <= '0;
            else if (r_map_set[w_ra1[MW-1:0]]) r_m1 <= r_map[w_ra1[MW-1:0]];
            else                           r_m1 <= 16'(FUEL_UNITY);
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_oval <= 1'b0;
        end else begin
            if (r_oval && !i_stall) r_oval <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (w_in_acc && i_command == CMD_EVAL) begin
                        r_eth  <= i_ethanol_estimate;
                        r_tc   <= i_coolant_count;
                        r_fuel_on <= r_fuel_en && i_cal_valid && (i_ethanol_estimate != 0)
                                     && i_engine_mode != MODE_INIT && i_engine_mode != MODE_OFF;
                        r_adv_on  <= r_adv_en && i_cal_valid && (i_ethanol_estimate != 0)
                                     && (i_engine_mode == MODE_OK || i_engine_mode == MODE_HOLD
                                         || i_engine_mode == MODE_OVERRIDE)
                                     && (i_coolant_count < r_adv_tmax);
                        r_axis <= 1'b0;
                        r_i    <= '0;
                        r_st   <= ST_SRCH;
                    end
                end
                ST_SRCH: begin
                    // walk segments one per cycle; endpoints settle at once
                    if (w_key <= w_first || w_key >= w_last || w_req.start
                        || 32'(r_i) == NP - 2) begin
                        if (r_axis) r_it <= (w_key <= w_first) ? '0 :
                                            (w_key >= w_last) ? IW'(NP-1) :
                                            w_req.start ? r_i : '0;
                        else        r_ie <= (w_key <= w_first) ? '0 :
                                            (w_key >= w_last) ? IW'(NP-1) :
                                            w_req.start ? r_i : '0;
                        if (r_axis) r_ft <= '0; else r_fe <= '0;
                        if (w_req.start) r_st <= ST_DIV;
                        else if (!r_axis) begin
                            r_axis <= 1'b1;
                            r_i    <= '0;
                        end else begin
                            r_step <= 3'd0;
                            r_st   <= ST_RD;
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                ST_DIV: begin
                    if (w_rsp.done) begin
                        if (r_axis) begin
                            r_ft   <= w_rsp.quo;
                            r_step <= 3'd0;
                            r_st   <= ST_RD;
                        end else begin
                            r_fe   <= w_rsp.quo;
                            r_axis <= 1'b1;
                            r_i    <= '0;
                            r_st   <= ST_SRCH;
                        end
                    end
                end
                ST_RD: begin
                    r_st <= ST_LD;
                end
                ST_LD: begin
                    // load the two end points of this lerp step
                    case (r_step)
                        3'd0, 3'd1: begin
                            r_a <= corner(r_m0);
                            r_b <= corner(r_m1);
                        end
                        3'd2: begin
                            r_a <= r_v;
                            r_b <= r_w;
                        end
                        default: begin
                            r_a <= w_cv0;
                            r_b <= w_cv1;
                        end
                    endcase
                    r_st <= ST_LERP;
                end
                ST_LERP: begin
                    r_prod <= $signed({1'b0, w_frac}) * (r_b - r_a);
                    r_st   <= ST_ADD;
                end
                ST_ADD: begin
                    case (r_step)
                        3'd0: begin
                            r_v    <= (r_ft != 0) ? w_lerp : r_a;
                            r_step <= 3'd1;
                            r_st   <= ST_RD;
                        end
                        3'd1: begin
                            r_w    <= (r_ft != 0) ? w_lerp : r_a;
                            r_step <= 3'd2;
                            r_st   <= ST_LD;
                        end
                        3'd2: begin
                            if (r_fe != 0) r_v <= w_lerp;
                            r_step <= 3'd3;
                            r_st   <= ST_LD;
                        end
                        default: begin
                            r_w  <= (r_fe != 0) ? w_lerp : r_a;
                            r_st <= ST_FIN;
                        end
                    endcase
                end
                ST_FIN: begin
                    // hold until the previous result has left the output register
                    if (!r_oval) begin
                        if (!r_fuel_on) r_of <= 12'(FUEL_UNITY);
                        else if (r_v < 18'sd0 + 18'(FUEL_UNITY)) r_of <= 12'(FUEL_UNITY);
                        else if (r_v > $signed({6'd0, w_fceil})) r_of <= w_fceil;
                        else r_of <= r_v[11:0];
                        if (!r_adv_on || r_w < 0) r_oa <= '0;
                        else if (r_w > $signed({10'd0, w_aceil})) r_oa <= w_aceil[6:0];
                        else r_oa <= r_w[6:0];
                        r_st <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_oval) begin
                        r_oval <= 1'b1;
                        r_st   <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_valid         = r_oval;
    assign o_start_factor  = r_of;
    assign o_start_advance = r_oa;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_IDLE) |-> o_stall) else $error("accept while busy");
    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_st == ST_DIV)) else $error("divider result outside divide");
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_start_factor >= 12'(FUEL_UNITY) && o_start_advance <= 7'(ADVANCE_HARD_MAX)))
        else $error("result out of range");
`endif
endmodule
